@@ rtl/mets_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Morse element timing sequencer.
// Holds sizes, codes, sequencer state types and the dit duration table.
// No dependencies.
package mets_pkg;

	localparam int MAX_PATTERNS = 64;
	localparam int MAX_ELEMENTS = 8;
	localparam int ADDR_W = 6;
	localparam int CNT_W = 7;
	localparam int EIDX_W = 4;
	localparam int SEL_W = 3;
	localparam int LEN_W = 4;
	localparam int BITS_W = 8;
	localparam int ENTRY_W = LEN_W + BITS_W;
	localparam int WPM_W = 6;
	localparam int TIME_W = 63;
	localparam int DIT_W = 18;
	localparam int DUR_W = 21;
	localparam int DIT_NUM = 1200000;

	localparam logic [WPM_W-1:0] WPM_MIN = 6'd5;
	localparam logic [WPM_W-1:0] WPM_MAX = 6'd60;
	localparam logic [WPM_W-1:0] WPM_RESET = 6'd20;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [2:0] {
		MODE_LOAD   = 3'd0,
		MODE_TICK   = 3'd1,
		MODE_PAUSE  = 3'd2,
		MODE_RESUME = 3'd3,
		MODE_ABORT  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		RUN_IDLE  = 2'd0,
		RUN_SEND  = 2'd1,
		RUN_PAUSE = 2'd2
	} run_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BUSY = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_EXEC,
		SEQ_READ,
		SEQ_NEXT,
		SEQ_ADD,
		SEQ_OUT
	} seq_t;

	typedef enum logic [2:0] {
		TA_NONE,
		TA_GAP,
		TA_CLEAR,
		TA_WORD,
		TA_NEXTPAT,
		TA_CHAR,
		TA_ELEM
	} tick_act_t;

	// Dit length in microseconds, indexed by words per minute.
	localparam logic [DIT_W-1:0] DIT_TABLE [64] = '{
		18'(DIT_NUM / 5),  18'(DIT_NUM / 5),  18'(DIT_NUM / 5),  18'(DIT_NUM / 5),
		18'(DIT_NUM / 5),  18'(DIT_NUM / 5),  18'(DIT_NUM / 6),  18'(DIT_NUM / 7),
		18'(DIT_NUM / 8),  18'(DIT_NUM / 9),  18'(DIT_NUM / 10), 18'(DIT_NUM / 11),
		18'(DIT_NUM / 12), 18'(DIT_NUM / 13), 18'(DIT_NUM / 14), 18'(DIT_NUM / 15),
		18'(DIT_NUM / 16), 18'(DIT_NUM / 17), 18'(DIT_NUM / 18), 18'(DIT_NUM / 19),
		18'(DIT_NUM / 20), 18'(DIT_NUM / 21), 18'(DIT_NUM / 22), 18'(DIT_NUM / 23),
		18'(DIT_NUM / 24), 18'(DIT_NUM / 25), 18'(DIT_NUM / 26), 18'(DIT_NUM / 27),
		18'(DIT_NUM / 28), 18'(DIT_NUM / 29), 18'(DIT_NUM / 30), 18'(DIT_NUM / 31),
		18'(DIT_NUM / 32), 18'(DIT_NUM / 33), 18'(DIT_NUM / 34), 18'(DIT_NUM / 35),
		18'(DIT_NUM / 36), 18'(DIT_NUM / 37), 18'(DIT_NUM / 38), 18'(DIT_NUM / 39),
		18'(DIT_NUM / 40), 18'(DIT_NUM / 41), 18'(DIT_NUM / 42), 18'(DIT_NUM / 43),
		18'(DIT_NUM / 44), 18'(DIT_NUM / 45), 18'(DIT_NUM / 46), 18'(DIT_NUM / 47),
		18'(DIT_NUM / 48), 18'(DIT_NUM / 49), 18'(DIT_NUM / 50), 18'(DIT_NUM / 51),
		18'(DIT_NUM / 52), 18'(DIT_NUM / 53), 18'(DIT_NUM / 54), 18'(DIT_NUM / 55),
		18'(DIT_NUM / 56), 18'(DIT_NUM / 57), 18'(DIT_NUM / 58), 18'(DIT_NUM / 59),
		18'(DIT_NUM / 60), 18'(DIT_NUM / 60), 18'(DIT_NUM / 60), 18'(DIT_NUM / 60)
	};

endpackage

@@ rtl/mets_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mets_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/morse_element_timing_sequencer_top.sv @@
`timescale 1ns / 1ps
// A load, pause, resume, abort or a tick that changes nothing goes from EXEC to OUT, where
// done pulses; a tick that times an element or a gap passes through ADD for the end time
// add, and a tick that must fetch the next pattern from the store before timing a gap
// passes through READ, NEXT and ADD. A new command word is taken only while busy is low.
// Reset clears the keyer to idle, unkeyed, with no patterns; speed returns to 20 wpm.
// The receiver cannot stall; each result is valid only while done is high.
// Depends on mets_pkg and mets_ram.
module morse_element_timing_sequencer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	output logic                             done,
	input  logic [2:0]                       mode,
	input  logic [mets_pkg::TIME_W-1:0]      now_us,
	input  logic [mets_pkg::BITS_W-1:0]      pattern_elements,
	input  logic [mets_pkg::LEN_W-1:0]       pattern_length,
	input  logic                             last_pattern,
	input  logic                             cfg_we,
	input  logic [mets_pkg::WPM_W-1:0]       cfg_wdata,
	output logic                             key_on,
	output logic [1:0]                       keyer_state,
	output logic [mets_pkg::CNT_W-1:0]       patterns_sent,
	output logic [mets_pkg::CNT_W-1:0]       patterns_total,
	output logic [1:0]                       status
);

	mets_pkg::seq_t                   state_q, state_d;
	mets_pkg::run_t                   run_q;
	mets_pkg::status_t                stat_q;
	mets_pkg::mode_t                  mode_q;
	mets_pkg::tick_act_t              act;
	logic [mets_pkg::TIME_W-1:0]      now_q;
	logic [mets_pkg::BITS_W-1:0]      bits_q;
	logic [mets_pkg::LEN_W-1:0]       len_q;
	logic                             last_q;
	logic [mets_pkg::CNT_W-1:0]       cnt_q, pidx_q;
	logic [mets_pkg::EIDX_W-1:0]      eidx_q;
	logic [mets_pkg::TIME_W-1:0]      end_q;
	logic                             key_q;
	logic [mets_pkg::WPM_W-1:0]       speed_q;
	logic [mets_pkg::DUR_W-1:0]       dur_q;

	logic                             mem_we;
	logic [mets_pkg::ENTRY_W-1:0]     mem_wdata, mem_rdata;
	logic [mets_pkg::LEN_W-1:0]       ent_len, len_clamped;
	logic [mets_pkg::BITS_W-1:0]      ent_bits;
	logic                             have_pat, more_pat, in_char, store_full;
	logic [mets_pkg::DIT_W-1:0]       dit;
	logic [mets_pkg::DUR_W-1:0]       d1, d3, d7;
	logic [mets_pkg::TIME_W:0]        sum;
	logic [mets_pkg::WPM_W-1:0]       wpm_clamped;

	mets_ram #(
		.WIDTH(mets_pkg::ENTRY_W),
		.DEPTH(mets_pkg::MAX_PATTERNS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(cnt_q[mets_pkg::ADDR_W-1:0]),
		.wdata(mem_wdata),
		.raddr(pidx_q[mets_pkg::ADDR_W-1:0]),
		.rdata(mem_rdata)
	);

	assign ent_len = mem_rdata[mets_pkg::ENTRY_W-1:mets_pkg::BITS_W];
	assign ent_bits = mem_rdata[mets_pkg::BITS_W-1:0];
	assign len_clamped = (len_q > mets_pkg::LEN_W'(mets_pkg::MAX_ELEMENTS)) ?
		mets_pkg::LEN_W'(mets_pkg::MAX_ELEMENTS) : len_q;
	assign mem_wdata = {len_clamped, bits_q};
	assign store_full = (cnt_q >= mets_pkg::CNT_W'(mets_pkg::MAX_PATTERNS));
	assign have_pat = (pidx_q < cnt_q);
	assign more_pat = ((pidx_q + mets_pkg::CNT_W'(1)) < cnt_q);
	assign in_char = have_pat && (ent_len != '0) && (mets_pkg::LEN_W'(eidx_q) < ent_len);
	assign dit = mets_pkg::DIT_TABLE[speed_q];
	assign d1 = mets_pkg::DUR_W'(dit);
	assign d3 = mets_pkg::DUR_W'({dit, 1'b0}) + mets_pkg::DUR_W'(dit);
	assign d7 = mets_pkg::DUR_W'({dit, 3'b000}) - mets_pkg::DUR_W'(dit);
	assign sum = {1'b0, now_q} + (mets_pkg::TIME_W + 1)'(dur_q);
	assign wpm_clamped = (cfg_wdata < mets_pkg::WPM_MIN) ? mets_pkg::WPM_MIN :
		((cfg_wdata > mets_pkg::WPM_MAX) ? mets_pkg::WPM_MAX : cfg_wdata);

	always_comb begin
		act = mets_pkg::TA_NONE;
		priority if (run_q != mets_pkg::RUN_SEND) begin
			act = mets_pkg::TA_NONE;
		end else if ((end_q != '0) && (now_q < end_q)) begin
			act = mets_pkg::TA_NONE;
		end else if ((end_q != '0) && key_q && in_char) begin
			act = mets_pkg::TA_GAP;
		end else if (!have_pat) begin
			act = mets_pkg::TA_CLEAR;
		end else if (ent_len == '0) begin
			act = mets_pkg::TA_WORD;
		end else if (mets_pkg::LEN_W'(eidx_q) >= ent_len) begin
			act = more_pat ? mets_pkg::TA_NEXTPAT : mets_pkg::TA_CHAR;
		end else begin
			act = mets_pkg::TA_ELEM;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mets_pkg::SEQ_IDLE: begin
				if (start) begin
					state_d = mets_pkg::SEQ_EXEC;
				end
			end
			mets_pkg::SEQ_EXEC: begin
				state_d = mets_pkg::SEQ_OUT;
				if (mode_q == mets_pkg::MODE_TICK) begin
					unique case (act)
						mets_pkg::TA_GAP, mets_pkg::TA_WORD, mets_pkg::TA_CHAR,
						mets_pkg::TA_ELEM:    state_d = mets_pkg::SEQ_ADD;
						mets_pkg::TA_NEXTPAT: state_d = mets_pkg::SEQ_READ;
						default:              state_d = mets_pkg::SEQ_OUT;
					endcase
				end
			end
			mets_pkg::SEQ_READ: state_d = mets_pkg::SEQ_NEXT;
			mets_pkg::SEQ_NEXT: state_d = mets_pkg::SEQ_ADD;
			mets_pkg::SEQ_ADD:  state_d = mets_pkg::SEQ_OUT;
			mets_pkg::SEQ_OUT:  state_d = mets_pkg::SEQ_IDLE;
			default:            state_d = mets_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != mets_pkg::SEQ_IDLE);
		done = (state_q == mets_pkg::SEQ_OUT);
		mem_we = (state_q == mets_pkg::SEQ_EXEC) && (mode_q == mets_pkg::MODE_LOAD) &&
			(run_q == mets_pkg::RUN_IDLE) && !store_full;
	end

	assign key_on = key_q;
	assign keyer_state = run_q;
	assign patterns_sent = pidx_q;
	assign patterns_total = cnt_q;
	assign status = stat_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mets_pkg::mode_t'(mode);
			now_q <= now_us;
			bits_q <= pattern_elements;
			len_q <= pattern_length;
			last_q <= last_pattern;
		end
		if (state_q == mets_pkg::SEQ_EXEC) begin
			unique case (act)
				mets_pkg::TA_GAP:  dur_q <= d1;
				mets_pkg::TA_WORD: dur_q <= d7;
				mets_pkg::TA_CHAR: dur_q <= d3;
				mets_pkg::TA_ELEM: dur_q <= ent_bits[eidx_q[mets_pkg::SEL_W-1:0]] ? d3 : d1;
				default:           dur_q <= dur_q;
			endcase
		end else if (state_q == mets_pkg::SEQ_NEXT) begin
			dur_q <= (ent_len == '0) ? d7 : d3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mets_pkg::SEQ_IDLE;
			run_q <= mets_pkg::RUN_IDLE;
			stat_q <= mets_pkg::STAT_OK;
			cnt_q <= '0;
			pidx_q <= '0;
			eidx_q <= '0;
			end_q <= '0;
			key_q <= 1'b0;
			speed_q <= mets_pkg::WPM_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				speed_q <= wpm_clamped;
			end
			unique case (state_q)
				mets_pkg::SEQ_EXEC: begin
					stat_q <= mets_pkg::STAT_OK;
					unique case (mode_q)
						mets_pkg::MODE_LOAD: begin
							if (run_q != mets_pkg::RUN_IDLE) begin
								stat_q <= mets_pkg::STAT_BUSY;
							end else begin
								if (!store_full) begin
									cnt_q <= cnt_q + mets_pkg::CNT_W'(1);
								end else begin
									stat_q <= mets_pkg::STAT_FULL;
								end
								if (last_q) begin
									run_q <= mets_pkg::RUN_SEND;
									pidx_q <= '0;
									eidx_q <= '0;
									end_q <= '0;
									key_q <= 1'b0;
								end
							end
						end
						mets_pkg::MODE_TICK: begin
							unique case (act)
								mets_pkg::TA_GAP: begin
									key_q <= 1'b0;
								end
								mets_pkg::TA_WORD, mets_pkg::TA_NEXTPAT,
								mets_pkg::TA_CHAR: begin
									key_q <= 1'b0;
									pidx_q <= pidx_q + mets_pkg::CNT_W'(1);
									eidx_q <= '0;
								end
								mets_pkg::TA_ELEM: begin
									key_q <= 1'b1;
									eidx_q <= eidx_q + mets_pkg::EIDX_W'(1);
								end
								mets_pkg::TA_CLEAR: begin
									run_q <= mets_pkg::RUN_IDLE;
									cnt_q <= '0;
									pidx_q <= '0;
									eidx_q <= '0;
									end_q <= '0;
									key_q <= 1'b0;
								end
								default: begin
								end
							endcase
						end
						mets_pkg::MODE_PAUSE: begin
							if (run_q == mets_pkg::RUN_SEND) begin
								key_q <= 1'b0;
								run_q <= mets_pkg::RUN_PAUSE;
							end
						end
						mets_pkg::MODE_RESUME: begin
							if (run_q == mets_pkg::RUN_PAUSE) begin
								run_q <= mets_pkg::RUN_SEND;
								end_q <= '0;
							end
						end
						mets_pkg::MODE_ABORT: begin
							run_q <= mets_pkg::RUN_IDLE;
							cnt_q <= '0;
							pidx_q <= '0;
							eidx_q <= '0;
							end_q <= '0;
							key_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				mets_pkg::SEQ_NEXT: begin
					key_q <= 1'b0;
					if (ent_len == '0) begin
						pidx_q <= pidx_q + mets_pkg::CNT_W'(1);
						eidx_q <= '0;
					end
				end
				mets_pkg::SEQ_ADD: begin
					end_q <= sum[mets_pkg::TIME_W] ? mets_pkg::TIME_MAX :
						sum[mets_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for morse_element_timing_sequencer_top: a queue-fed driver, a
// monitor and a cycle-free keyer predictor check every result word field by field.
// Depends on mets_pkg and the sequencer RTL.
module tb_top;
	import mets_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam logic [2:0] MODE_SPARE_FIRST = 3'(MODE_ABORT) + 3'd1;

	typedef struct {
		logic [2:0] mode;
		logic [TIME_W-1:0] now;
		logic [BITS_W-1:0] bits;
		logic [LEN_W-1:0] len;
		logic last;
	} key_cmd_t;

	typedef struct packed {
		logic key;
		logic [1:0] state;
		logic [CNT_W-1:0] sent;
		logic [CNT_W-1:0] total;
		logic [1:0] stat;
	} keyer_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] mode = 3'(MODE_LOAD);
	logic [TIME_W-1:0] now_us = '0;
	logic [BITS_W-1:0] pattern_elements = '0;
	logic [LEN_W-1:0] pattern_length = '0;
	logic last_pattern = 1'b0;
	logic cfg_we = 1'b0;
	logic [WPM_W-1:0] cfg_wdata = '0;
	logic busy, done, key_on;
	logic [1:0] keyer_state, status;
	logic [CNT_W-1:0] patterns_sent, patterns_total;

	key_cmd_t pending_cmds[$];
	keyer_view_t expected_views[$];
	key_cmd_t cur_cmd;
	keyer_view_t want_view;
	bit holding;
	bit gaps_on = 1'b1;
	int unsigned gen_count, cmds_accepted, results_seen, mismatches, quiet_cycles;
	int unsigned messages_keyed, store_fills;
	logic [TIME_W-1:0] stim_now = '0;

	// Keyer state as the predictor sees it.
	logic [WPM_W-1:0] model_wpm = WPM_RESET;
	run_t model_run = RUN_IDLE;
	logic [BITS_W-1:0] model_bits [MAX_PATTERNS];
	logic [LEN_W-1:0] model_len [MAX_PATTERNS];
	int unsigned model_count, model_index, model_elem;
	logic [TIME_W-1:0] model_end = '0;
	logic model_key = 1'b0;

	morse_element_timing_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.mode(mode),
		.now_us(now_us),
		.pattern_elements(pattern_elements),
		.pattern_length(pattern_length),
		.last_pattern(last_pattern),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.key_on(key_on),
		.keyer_state(keyer_state),
		.patterns_sent(patterns_sent),
		.patterns_total(patterns_total),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned dit_len();
		return DIT_NUM / model_wpm;
	endfunction

	function automatic logic [TIME_W-1:0] end_after(logic [TIME_W-1:0] t, int unsigned dur);
		if (t > TIME_MAX - dur)
			return TIME_MAX;
		return t + dur;
	endfunction

	function automatic void clear_keyer();
		model_run = RUN_IDLE;
		model_count = 0;
		model_index = 0;
		model_elem = 0;
		model_end = '0;
		model_key = 1'b0;
	endfunction

	function automatic bit start_element(logic [TIME_W-1:0] t);
		int unsigned d;
		d = dit_len();
		while (1) begin
			if (model_index >= model_count)
				return 1'b0;
			if (model_len[model_index] == 0) begin
				model_end = end_after(t, 7 * d);
				model_key = 1'b0;
				model_index++;
				model_elem = 0;
				return 1'b1;
			end
			if (model_elem >= model_len[model_index]) begin
				model_index++;
				model_elem = 0;
				// A word gap right after a character takes the place of the character gap.
				if (model_index < model_count && model_len[model_index] == 0)
					continue;
				model_end = end_after(t, 3 * d);
				model_key = 1'b0;
				return 1'b1;
			end
			if (model_bits[model_index][model_elem])
				model_end = end_after(t, 3 * d);
			else
				model_end = end_after(t, d);
			model_key = 1'b1;
			model_elem++;
			return 1'b1;
		end
	endfunction

	function automatic void tick_keyer(logic [TIME_W-1:0] t);
		if (model_run != RUN_SEND)
			return;
		if (model_end != '0) begin
			if (t < model_end)
				return;
			if (model_key) begin
				model_key = 1'b0;
				if (model_index < model_count && model_len[model_index] != 0 &&
				    model_elem < model_len[model_index]) begin
					model_end = end_after(t, dit_len());
					return;
				end
			end
			model_end = '0;
		end
		if (!start_element(t))
			clear_keyer();
	endfunction

	function automatic status_t load_pattern(logic [BITS_W-1:0] b, logic [LEN_W-1:0] l,
	                                         logic la);
		status_t st;
		st = STAT_OK;
		if (model_run != RUN_IDLE)
			return STAT_BUSY;
		if (l > MAX_ELEMENTS)
			l = LEN_W'(MAX_ELEMENTS);
		if (model_count < MAX_PATTERNS) begin
			model_bits[model_count] = b;
			model_len[model_count] = l;
			model_count++;
		end else begin
			st = STAT_FULL;
		end
		if (la && model_count > 0) begin
			model_run = RUN_SEND;
			model_index = 0;
			model_elem = 0;
			model_end = '0;
			model_key = 1'b0;
			messages_keyed++;
		end
		return st;
	endfunction

	function automatic keyer_view_t predict_view(key_cmd_t c);
		keyer_view_t v;
		v.stat = STAT_OK;
		case (c.mode)
			MODE_LOAD: v.stat = load_pattern(c.bits, c.len, c.last);
			MODE_TICK: tick_keyer(c.now);
			MODE_PAUSE: begin
				if (model_run == RUN_SEND) begin
					model_key = 1'b0;
					model_run = RUN_PAUSE;
				end
			end
			MODE_RESUME: begin
				if (model_run == RUN_PAUSE) begin
					model_run = RUN_SEND;
					model_end = '0;
				end
			end
			MODE_ABORT: clear_keyer();
			default: ;
		endcase
		v.key = model_key;
		v.state = model_run;
		v.sent = CNT_W'(model_index);
		v.total = CNT_W'(model_count);
		return v;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("ERROR result %0d: %s is %0d, expected %0d", results_seen, field, got,
		         want);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			holding = 1'b0;
			if (start && !busy) begin
				expected_views.push_back(predict_view(cur_cmd));
				cmds_accepted++;
			end else begin
				holding = start;
			end
			if (!holding) begin
				if (pending_cmds.size() != 0 && (!gaps_on || $urandom_range(0, 99) >= 28)) begin
					cur_cmd = pending_cmds.pop_front();
					mode <= cur_cmd.mode;
					now_us <= cur_cmd.now;
					pattern_elements <= cur_cmd.bits;
					pattern_length <= cur_cmd.len;
					last_pattern <= cur_cmd.last;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_views.size() == 0) begin
				report_mismatch("word with nothing pending", 1, 0);
			end else begin
				want_view = expected_views.pop_front();
				if (key_on !== want_view.key)
					report_mismatch("key_on", key_on, want_view.key);
				if (keyer_state !== want_view.state)
					report_mismatch("keyer_state", keyer_state, want_view.state);
				if (patterns_sent !== want_view.sent)
					report_mismatch("patterns_sent", patterns_sent, want_view.sent);
				if (patterns_total !== want_view.total)
					report_mismatch("patterns_total", patterns_total, want_view.total);
				if (status !== want_view.stat)
					report_mismatch("status", status, want_view.stat);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("morse_element_timing_sequencer_top: mismatch");
				$finish;
			end
		end
	end

	task automatic push_cmd(logic [2:0] m, logic [TIME_W-1:0] t, logic [BITS_W-1:0] b,
	                        logic [LEN_W-1:0] l, logic la);
		key_cmd_t c;
		c.mode = m;
		c.now = t;
		c.bits = b;
		c.len = l;
		c.last = la;
		pending_cmds.push_back(c);
		gen_count++;
	endtask

	task automatic push_tick(int unsigned step);
		stim_now = end_after(stim_now, step);
		push_cmd(MODE_TICK, stim_now, BITS_W'($urandom), LEN_W'($urandom), 1'($urandom));
	endtask

	task automatic push_noise();
		push_cmd(3'($urandom), TIME_W'({$urandom, $urandom}), BITS_W'($urandom),
		         LEN_W'($urandom), 1'($urandom));
	endtask

	task automatic set_speed(logic [WPM_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_wpm = (v < WPM_MIN) ? WPM_MIN : (v > WPM_MAX) ? WPM_MAX : v;
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || start || expected_views.size() != 0)
			@(posedge clk);
	endtask

	// Loads a message and then ticks it through; enough ticks are sure to expire an
	// element that the whole message is normally sent.
	task automatic send_message(int unsigned n);
		int unsigned need, fast, len, r, d;
		d = dit_len();
		r = $urandom_range(0, 9);
		if (r < 2)
			stim_now = TIME_W'({$urandom, $urandom});
		else if (r < 4)
			stim_now = TIME_MAX - TIME_W'($urandom_range(0, 20 * d));
		need = 2;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			len = (r < 15) ? 0 : (r < 20) ? $urandom_range(9, 15) :
			      $urandom_range(1, MAX_ELEMENTS);
			push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'(len), i == n - 1);
			need += (len == 0) ? 1 : 2 * ((len > MAX_ELEMENTS) ? MAX_ELEMENTS : len);
		end
		fast = 0;
		while (fast < need) begin
			r = $urandom_range(0, 99);
			if (r == 0) begin
				push_cmd(MODE_ABORT, stim_now, '0, '0, 1'b0);
				return;
			end else if (r < 5) begin
				push_cmd(MODE_PAUSE, stim_now, '0, '0, 1'b0);
				if (r < 3)
					push_tick($urandom_range(0, 8 * d));
				push_cmd(MODE_RESUME, stim_now, '0, '0, 1'b0);
			end else if (r < 8) begin
				push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'($urandom), 1'($urandom));
			end else if (r < 30) begin
				push_tick($urandom_range(0, 3 * d));
			end else begin
				push_tick(7 * d + $urandom_range(0, d));
				fast++;
			end
		end
	endtask

	task automatic fill_store();
		push_cmd(MODE_ABORT, stim_now, '0, '0, 1'b0);
		for (int i = 0; i < MAX_PATTERNS; i++)
			push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom),
			         LEN_W'($urandom_range(0, MAX_ELEMENTS)), 1'b0);
		push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'($urandom), 1'b0);
		push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'($urandom), 1'b1);
		repeat (8)
			push_tick(7 * dit_len() + 1);
		push_cmd(MODE_ABORT, stim_now, '0, '0, 1'b0);
		store_fills++;
	endtask

	initial begin
		int unsigned target, r;
		logic [WPM_W-1:0] speeds [4];
		speeds = '{'1, '0, WPM_MIN, WPM_MAX};
		clear_keyer();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Idle-state commands, clamped loads, a busy load, pause and resume, then a
		// message timed at the very top of the time range.
		push_cmd(MODE_TICK, TIME_MAX, '0, '0, 1'b0);
		push_cmd(MODE_PAUSE, '0, '0, '0, 1'b0);
		push_cmd(MODE_RESUME, '0, '0, '0, 1'b0);
		push_cmd(MODE_SPARE_FIRST + 3'd2, TIME_MAX, '1, '1, 1'b1);
		push_cmd(MODE_ABORT, '0, '0, '0, 1'b0);
		push_cmd(MODE_LOAD, '0, '1, '1, 1'b0);
		push_cmd(MODE_LOAD, '0, '0, '0, 1'b0);
		push_cmd(MODE_LOAD, '0, '0, LEN_W'(1), 1'b1);
		push_cmd(MODE_LOAD, '0, 8'hAA, LEN_W'(MAX_ELEMENTS), 1'b1);
		push_cmd(MODE_TICK, '0, '0, '0, 1'b0);
		push_cmd(MODE_TICK, TIME_W'(1), '0, '0, 1'b0);
		push_cmd(MODE_PAUSE, '0, '0, '0, 1'b0);
		push_cmd(MODE_TICK, TIME_MAX, '0, '0, 1'b0);
		push_cmd(MODE_RESUME, '0, '0, '0, 1'b0);
		push_cmd(MODE_TICK, TIME_W'(2), '0, '0, 1'b0);
		push_cmd(MODE_ABORT, '0, '0, '0, 1'b0);
		push_cmd(MODE_LOAD, '0, '0, LEN_W'(1), 1'b1);
		push_cmd(MODE_TICK, TIME_MAX - TIME_W'(5), '0, '0, 1'b0);
		push_cmd(MODE_TICK, TIME_MAX, '0, '0, 1'b0);
		push_cmd(MODE_TICK, TIME_MAX, '0, '0, 1'b0);
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			set_speed(p < 4 ? speeds[p] : WPM_W'($urandom));
			gaps_on = (p != 1);
			stim_now = '0;
			target = gen_count + 300;
			if (p == 0 || p == 3)
				fill_store();
			while (gen_count < target) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					send_message(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) :
					             $urandom_range(1, 5));
				end else if (r < 82) begin
					repeat ($urandom_range(1, 6))
						push_noise();
					if ($urandom_range(0, 9) < 7)
						push_cmd(MODE_ABORT, stim_now, '0, '0, 1'b0);
				end else begin
					repeat ($urandom_range(1, 3))
						push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'($urandom),
						         1'($urandom));
					repeat ($urandom_range(0, 4))
						push_tick($urandom_range(0, 8 * dit_len()));
					push_cmd(MODE_LOAD, stim_now, BITS_W'($urandom), LEN_W'($urandom), 1'b1);
					push_cmd(MODE_ABORT, stim_now, '0, '0, 1'b0);
				end
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d command words and %0d results over seven speed settings,",
		         cmds_accepted, results_seen);
		$display("with %0d messages keyed and %0d full-store runs.", messages_keyed,
		         store_fills);
		if (mismatches == 0 && expected_views.size() == 0) begin
			$display("morse_element_timing_sequencer_top: match");
		end else begin
			$display("morse_element_timing_sequencer_top: mismatch");
		end
		$finish;
	end

endmodule
